FILE: rtl/core/rgb_colour_sequencer_classifier_macros.svh
// Assertion macros for the colour sequencer core.
// Each check samples on clk and is disabled while rst_n is low.
`ifndef RGB_COLOUR_SEQUENCER_CLASSIFIER_MACROS_SVH
`define RGB_COLOUR_SEQUENCER_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define RCSC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcsc check failed");

// Next-cycle implication.
`define RCSC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcsc check failed");

`else

`define RCSC_ASSERT_IMP(label, ante, cons)
`define RCSC_ASSERT_NXT(label, ante, cons)

`endif

`endif

FILE: rtl/core/rcsc_pkg.sv
package rcsc_pkg;

    localparam int SAMPLE_BITS   = 10;
    localparam int PHASE_BITS    = 6;
    localparam int CYCLE_BITS    = 8;
    localparam int CFG_DATA_BITS = 8;
    localparam int CFG_IDX_BITS  = 1;

    localparam logic [PHASE_BITS-1:0] PHASE_LENGTH_RESET = PHASE_BITS'(10);
    localparam logic [CYCLE_BITS-1:0] CYCLE_LENGTH_RESET = CYCLE_BITS'(40);

    // floor(x/3) = (x * ceil(2^(n+1)/3)) >> (n+1) for every n-bit x
    localparam int DIV3_SHIFT = SAMPLE_BITS + 1;
    localparam logic [DIV3_SHIFT-1:0] DIV3_MULT = DIV3_SHIFT'(((1 << DIV3_SHIFT) + 2) / 3);
    localparam int DIV3_PROD_BITS = SAMPLE_BITS + DIV3_SHIFT;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        COL_NONE  = 2'd0,
        COL_RED   = 2'd1,
        COL_GREEN = 2'd2,
        COL_BLUE  = 2'd3
    } colour_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PHASE_LENGTH = 1'b0,
        REG_CYCLE_LENGTH = 1'b1
    } cfg_reg_t;

    localparam logic [2:0] LED_NONE  = 3'b000;
    localparam logic [2:0] LED_RED   = 3'b001;
    localparam logic [2:0] LED_GREEN = 3'b010;
    localparam logic [2:0] LED_BLUE  = 3'b100;

endpackage

FILE: rtl/core/rcsc_in_if.sv
interface rcsc_in_if
    import rcsc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [1:0]             opcode;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output opcode, output sample, input ready);
    modport sink   (input valid, input opcode, input sample, output ready);
endinterface

FILE: rtl/core/rcsc_out_if.sv
interface rcsc_out_if
    import rcsc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [1:0]            colour;
    logic [2:0]            emitter_on;
    logic [2:0]            indicator;
    logic [CYCLE_BITS-1:0] tick_count;

    modport source (output valid, output colour, output emitter_on, output indicator,
                    output tick_count, input ready);
    modport sink   (input valid, input colour, input emitter_on, input indicator,
                    input tick_count, output ready);
endinterface

FILE: rtl/core/rgb_colour_sequencer_classifier.sv
// Each accepted word updates the state and result registers, which then hold its result word.
// Throughput: one word per cycle unless the output stalls; the state update is a single pass of compare,
// constant-divide and select logic feeding the state and result registers.
// Input is taken whenever the result register is empty or being drained.
// Reset (rst_n, async, active low) clears counter, levels, phase, LEDs and the result
// register, and loads phase_length = 10 and cycle_length = 40.
`include "rgb_colour_sequencer_classifier_macros.svh"

module rgb_colour_sequencer_classifier
    import rcsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    rcsc_in_if.sink                  in_ch,
    rcsc_out_if.source               out_ch
);

    logic [PHASE_BITS-1:0]  phase_length_reg;
    logic [CYCLE_BITS-1:0]  cycle_length_reg;
    logic [CYCLE_BITS-1:0]  tick_counter_reg, tick_counter_next;
    logic                   started_reg, started_next;
    colour_t                active_phase_reg, active_phase_next;
    logic [SAMPLE_BITS-1:0] red_level_reg, red_level_next;
    logic [SAMPLE_BITS-1:0] green_level_reg, green_level_next;
    logic [SAMPLE_BITS-1:0] blue_level_reg, blue_level_next;
    colour_t                last_colour_reg, last_colour_next;
    logic [2:0]             indicator_reg, indicator_next;
    logic [2:0]             emitter_reg, emitter_next;

    logic                   out_valid_reg;
    colour_t                out_colour_reg, colour_next;

    logic                    accept;
    opcode_t                 op;
    logic [CYCLE_BITS-1:0]   tick_inc;
    logic [CYCLE_BITS-1:0]   t_query;
    logic [CYCLE_BITS-1:0]   p1, p2, p3;
    logic [DIV3_PROD_BITS-1:0] div3_prod;
    logic [SAMPLE_BITS-1:0]  green_scaled;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign op          = opcode_t'(in_ch.opcode);

    assign tick_inc  = tick_counter_reg + CYCLE_BITS'(1);
    assign t_query   = started_reg ? tick_counter_reg : '0;
    assign p1        = CYCLE_BITS'(phase_length_reg);
    assign p2        = CYCLE_BITS'({phase_length_reg, 1'b0});
    assign p3        = p2 + p1;

    // green stored as (x/3)*2; the quotient is at most a third of full scale
    assign div3_prod    = DIV3_PROD_BITS'(in_ch.sample) * DIV3_PROD_BITS'(DIV3_MULT);
    assign green_scaled = {div3_prod[DIV3_SHIFT +: SAMPLE_BITS-1], 1'b0};

    always_comb
    begin
        tick_counter_next = tick_counter_reg;
        started_next      = started_reg;
        active_phase_next = active_phase_reg;
        red_level_next    = red_level_reg;
        green_level_next  = green_level_reg;
        blue_level_next   = blue_level_reg;
        last_colour_next  = last_colour_reg;
        indicator_next    = indicator_reg;
        emitter_next      = emitter_reg;
        colour_next       = COL_NONE;

        case (op)
            OP_TICK:
            begin
                tick_counter_next = (tick_inc >= cycle_length_reg) ? '0 : tick_inc;
            end
            OP_SAMPLE:
            begin
                case (active_phase_reg)
                    COL_RED:   red_level_next   = in_ch.sample;
                    COL_GREEN: green_level_next = green_scaled;
                    COL_BLUE:  blue_level_next  = in_ch.sample;
                    default:   ;
                endcase
            end
            OP_QUERY:
            begin
                // first query restarts the count before picking a phase
                started_next      = 1'b1;
                tick_counter_next = t_query;
                if (t_query < p1)
                begin
                    active_phase_next = COL_RED;
                    emitter_next      = LED_RED;
                end
                else if (t_query < p2)
                begin
                    active_phase_next = COL_GREEN;
                    emitter_next      = LED_GREEN;
                end
                else if (t_query < p3)
                begin
                    active_phase_next = COL_BLUE;
                    emitter_next      = LED_BLUE;
                end
                else
                begin
                    active_phase_next = COL_NONE;
                    emitter_next      = LED_NONE;
                    if (red_level_reg >= green_level_reg && red_level_reg >= blue_level_reg)
                    begin
                        last_colour_next = COL_RED;
                        indicator_next   = LED_RED;
                    end
                    else if (green_level_reg >= blue_level_reg)
                    begin
                        last_colour_next = COL_GREEN;
                        indicator_next   = LED_GREEN;
                    end
                    else
                    begin
                        last_colour_next = COL_BLUE;
                        indicator_next   = LED_BLUE;
                    end
                    colour_next = last_colour_next;
                end
            end
            OP_CLEAR:
            begin
                tick_counter_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_length_reg <= PHASE_LENGTH_RESET;
            cycle_length_reg <= CYCLE_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PHASE_LENGTH: phase_length_reg <= cfg_data[PHASE_BITS-1:0];
                REG_CYCLE_LENGTH: cycle_length_reg <= cfg_data[CYCLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_counter_reg <= '0;
            started_reg      <= 1'b0;
            active_phase_reg <= COL_NONE;
            red_level_reg    <= '0;
            green_level_reg  <= '0;
            blue_level_reg   <= '0;
            last_colour_reg  <= COL_NONE;
            indicator_reg    <= LED_NONE;
            emitter_reg      <= LED_NONE;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                tick_counter_reg <= tick_counter_next;
                started_reg      <= started_next;
                active_phase_reg <= active_phase_next;
                red_level_reg    <= red_level_next;
                green_level_reg  <= green_level_next;
                blue_level_reg   <= blue_level_next;
                last_colour_reg  <= last_colour_next;
                indicator_reg    <= indicator_next;
                emitter_reg      <= emitter_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result word payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_colour_reg <= COL_NONE;
        end
        else if (accept)
        begin
            out_colour_reg <= colour_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.colour     = out_colour_reg;
    assign out_ch.emitter_on = emitter_reg;
    assign out_ch.indicator  = indicator_reg;
    assign out_ch.tick_count = tick_counter_reg;

    `RCSC_ASSERT_IMP(a_emitter_matches_phase,
        1'b1, (active_phase_reg == COL_NONE) == (emitter_reg == LED_NONE))
    `RCSC_ASSERT_IMP(a_indicator_tracks_colour,
        1'b1, $onehot0(indicator_reg) &&
              ((last_colour_reg == COL_NONE) == (indicator_reg == LED_NONE)))
    `RCSC_ASSERT_NXT(a_accept_gives_result,
        accept, out_valid_reg)
    `RCSC_ASSERT_NXT(a_query_sets_started,
        accept && op == OP_QUERY, started_reg)

endmodule
